/* hdl/base64_lenient_decoder_defines.svh */
// ----------------------------------------------------------------------------
// base64 lenient decoder: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef BASE64_LENIENT_DECODER_DEFINES_SVH
`define BASE64_LENIENT_DECODER_DEFINES_SVH

// same-cycle implication
`define B64D_ASSERT_NOW(name, clk, rst, ant, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
      else $error("%m: assertion failed");

// next-cycle implication
`define B64D_ASSERT_NEXT(name, clk, rst, ant, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

/* hdl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types and the alphabet lookup shared by the base64 decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam int unsigned BurstMax = 3;

   // one group of results caused by a single character
   typedef struct packed {
      logic [1:0]                   last_idx;  // index of the last result
      logic [BurstMax-1:0][7:0]     data;      // data[0] goes out first
      logic                         fin;       // last result closes the text
      logic                         bare;      // single end marker, no data
   } burst_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sextet_type;

   function automatic sextet_type sextet(input logic [7:0] c);
      sextet_type s;
      s.hit   = 1'b1;
      s.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin         // A-Z
         s.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin  // a-z
         s.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin  // 0-9
         s.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin                // '+'
         s.value = 6'd62;
      end else if (c == 8'h2F) begin                // '/'
         s.value = 6'd63;
      end else begin
         s.hit = 1'b0;
      end
      return s;
   endfunction

endpackage

/* hdl/b64d_unpack.sv */
// ----------------------------------------------------------------------------
// b64d_unpack
// Holds the partial sextet group and turns an accepted character that completes
// a group or ends the text into a burst of results (end-of-text flush).
// ----------------------------------------------------------------------------
module b64d_unpack (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          text_char,
   input  logic                end_of_text,
   output logic                has_burst,
   output b64d_pkg::burst_type burst
);

   logic [17:0]            acc_ff, acc_in;
   logic [1:0]             cnt_ff, cnt_in;
   b64d_pkg::sextet_type   sx;
   logic [23:0]            acc_new;
   logic [2:0]             cnt_sum;
   logic                   full;

   always_comb begin
      sx      = b64d_pkg::sextet(text_char);
      acc_new = sx.hit ? {acc_ff, sx.value} : {6'd0, acc_ff};
      cnt_sum = {1'b0, cnt_ff} + {2'b00, sx.hit};
      full    = (cnt_sum == 3'd4);

      has_burst      = 1'b0;
      burst.last_idx = 2'd0;
      burst.data     = '0;
      burst.fin      = end_of_text;
      burst.bare     = 1'b0;

      if (full) begin
         has_burst      = 1'b1;
         burst.last_idx = 2'd2;
         burst.data[0]  = acc_new[23:16];
         burst.data[1]  = acc_new[15:8];
         burst.data[2]  = acc_new[7:0];
      end else if (end_of_text) begin
         has_burst = 1'b1;
         case (cnt_sum)
            3'd3: begin
               burst.last_idx = 2'd1;
               burst.data[0]  = acc_new[17:10];
               burst.data[1]  = acc_new[9:2];
            end
            3'd2: begin
               burst.data[0] = acc_new[11:4];
            end
            default: begin
               burst.bare = 1'b1;  // one char or none: end marker only
            end
         endcase
      end

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      if (take) begin
         if (full || end_of_text) begin
            acc_in = '0;
            cnt_in = '0;
         end else if (sx.hit) begin
            acc_in = acc_new[17:0];
            cnt_in = cnt_sum[1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

/* hdl/base64_lenient_decoder.sv */
// ----------------------------------------------------------------------------
// base64_lenient_decoder
// Lenient streaming base64 decoder: skips non-alphabet characters and emits
// three bytes per four characters, flushing the partial group at end of text.
// ----------------------------------------------------------------------------
// Output: first result of a character is shown the cycle after its transfer
//   when the output is idle, else once the results ahead of it have drained.
// Rate: one character per cycle while no burst is queued; a character's results
//   hold the output until all are taken, and one further burst is queued behind it.
// While a burst sits in the queue, req_ready is low for every character.
// Reset (synchronous): clears the held group, the queue and the output.
// ----------------------------------------------------------------------------
module base64_lenient_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_char,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_final_result
);

   logic                take;
   logic                has_burst;
   b64d_pkg::burst_type new_burst;

   b64d_pkg::burst_type pend_ff, pend_in;
   logic                pend_valid_ff, pend_valid_in;
   b64d_pkg::burst_type out_ff, out_in;
   logic                out_valid_ff, out_valid_in;
   logic [1:0]          idx_ff, idx_in;
   logic                out_xfer, out_done, out_free, new_item;

   assign req_ready = !pend_valid_ff;
   assign take      = req_valid && req_ready;

   b64d_unpack u_unpack (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .text_char   (req_text_char),
      .end_of_text (req_end_of_text),
      .has_burst   (has_burst),
      .burst       (new_burst)
   );

   always_comb begin
      new_item = take && has_burst;
      out_xfer = out_valid_ff && rsp_ready;
      out_done = out_xfer && (idx_ff == out_ff.last_idx);
      out_free = !out_valid_ff || out_done;

      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      idx_in        = idx_ff;

      if (out_xfer && !out_done) begin
         idx_in = idx_ff + 2'd1;
      end

      if (out_free) begin
         idx_in = 2'd0;
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_in       = new_burst;
            pend_valid_in = new_item;
         end else begin
            out_in       = new_burst;
            out_valid_in = new_item;
         end
      end else if (new_item) begin
         // output busy; queue slot is free since the transfer needed ready
         pend_in       = new_burst;
         pend_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= 2'd0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_ff.bare ? 8'd0 : out_ff.data[idx_ff];
   assign rsp_byte_valid   = !out_ff.bare;
   assign rsp_final_result = out_ff.fin && (idx_ff == out_ff.last_idx);

endmodule

/* hdl/b64d_checker.sv */
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks for the base64 decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_lenient_decoder_defines.svh"

module b64d_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_end_of_text,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_byte_valid,
   input logic       rsp_final_result
);

   logic req_xfer;
   assign req_xfer = req_valid && req_ready;

   // a bare marker only ever closes a text
   `B64D_ASSERT_NOW(a_bare_is_final, clock, reset, rsp_valid && !rsp_byte_valid, rsp_final_result)
   // a bare marker carries a zero byte
   `B64D_ASSERT_NOW(a_bare_zero, clock, reset, rsp_valid && !rsp_byte_valid, rsp_out_byte == 8'd0)
   // after an end-of-text transfer a result is always valid next cycle
   `B64D_ASSERT_NEXT(a_end_gives_rsp, clock, reset, req_xfer && req_end_of_text, rsp_valid)
   // a stalled result holds
   `B64D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte))

endmodule

bind base64_lenient_decoder b64d_checker u_b64d_checker (.*);

/* dv/base64_lenient_decoder_tb.sv */
// ----------------------------------------------------------------------------
// base64_lenient_decoder_tb
// Self-checking bench for the lenient base64 decoder. Text characters go in
// over valid/ready in random bursts. A scoreboard mirrors the sextet group
// accumulator, works out the bytes each accepted character should produce,
// and compares every result transfer against them in order.
// ----------------------------------------------------------------------------
module base64_lenient_decoder_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam bit [8*64-1:0] B64_ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int RANDOM_ITEMS   = 250;
   localparam int LONG_HOLD      = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_text_char;
   logic       req_end_of_text;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_out_byte;
   logic       rsp_byte_valid;
   logic       rsp_final_result;

   class b64_scoreboard;
      typedef struct packed {
         logic [7:0] data;
         logic       data_valid;
         logic       fin;
      } decoded_type;

      decoded_type expected_q[$];
      bit [23:0]   group_bits;
      int          group_count;
      int          errors;

      function new();
         group_bits  = '0;
         group_count = 0;
         errors      = 0;
      endfunction

      // index in the alphabet, -1 when the character is skipped
      function int sextet_value(bit [7:0] c);
         for (int i = 0; i < 64; i++) begin
            if (B64_ALPHABET[8*(63-i) +: 8] == c) return i;
         end
         return -1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_char(bit [7:0] c, bit eot);
         int          v;
         int          n_bytes;
         bit [7:0]    bytes_out[3];
         decoded_type d;
         v       = sextet_value(c);
         n_bytes = 0;
         if (v >= 0) begin
            group_bits  = {group_bits[17:0], 6'(v)};
            group_count = group_count + 1;
            if (group_count == 4) begin
               bytes_out[0] = group_bits[23:16];
               bytes_out[1] = group_bits[15:8];
               bytes_out[2] = group_bits[7:0];
               n_bytes      = 3;
               group_bits   = '0;
               group_count  = 0;
            end
         end
         if (eot) begin
            // partial group flush: leftover low bits are dropped
            if (group_count == 3) begin
               bytes_out[0] = group_bits[17:10];
               bytes_out[1] = group_bits[9:2];
               n_bytes      = 2;
            end else if (group_count == 2) begin
               bytes_out[0] = group_bits[11:4];
               n_bytes      = 1;
            end
            group_bits  = '0;
            group_count = 0;
            if (n_bytes == 0) begin
               d = '{data: 8'h00, data_valid: 1'b1 ^ 1'b1, fin: 1'b1};
               expected_q = {expected_q, d};
            end
         end
         for (int k = 0; k < n_bytes; k++) begin
            d = '{data: bytes_out[k], data_valid: 1'b1, fin: eot && (k == n_bytes - 1)};
            expected_q = {expected_q, d};
         end
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         errors++;
      endtask

      task check_byte(logic [7:0] data, logic data_valid, logic fin);
         decoded_type d;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result byte=%h valid=%b fin=%b",
                                      data, data_valid, fin));
         end else begin
            d = expected_q.pop_front();
            if (data !== d.data)
               report_mismatch($sformatf("out_byte got %h exp %h", data, d.data));
            if (data_valid !== d.data_valid)
               report_mismatch($sformatf("byte_valid got %b exp %b",
                                         data_valid, d.data_valid));
            if (fin !== d.fin)
               report_mismatch($sformatf("final_result got %b exp %b", fin, d.fin));
         end
      endtask
   endclass

   b64_scoreboard sb = new();

   int  burst_left;
   int  counted_items;
   int  quiet_cycles;
   bit  hold_off_pending;

   base64_lenient_decoder u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_text_char    (req_text_char),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_final_result (rsp_final_result)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // transfer monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_char(req_text_char, req_end_of_text);
         if (rsp_valid && rsp_ready)
            sb.check_byte(rsp_out_byte, rsp_byte_valid, rsp_final_result);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver: picks a random stall pattern for each random span, or holds off when asked
   initial begin : rsp_side
      int mode;
      int span;
      int phase;
      mode  = 0;
      span  = 0;
      phase = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (span == 0) begin
               mode = $urandom_range(0, 3);
               span = $urandom_range(20, 60);
            end
            span--;
            phase++;
            case (mode)
               0: begin
                  rsp_ready <= 1'b1;
               end
               1: begin
                  rsp_ready <= 1'($urandom_range(0, 1));
               end
               2: begin
                  rsp_ready <= ($urandom_range(0, 3) == 0);
               end
               default: begin
                  rsp_ready <= (phase % 5) != 4;
               end
            endcase
         end
      end
   end

   function automatic bit [7:0] pick_b64_char();
      return B64_ALPHABET[8*$urandom_range(0, 63) +: 8];
   endfunction

   task automatic send_char(input bit [7:0] c, input bit eot);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      counted_items++;
      req_valid       <= 1'b1;
      req_text_char   <= c;
      req_end_of_text <= eot;
      do @(posedge clock); while (!req_ready);
   endtask

   // sender stops until every outstanding result has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      burst_left = 0;
   endtask

   // mostly well-formed text with some noise and optional padding
   task automatic send_text();
      bit [7:0] text_q[$];
      int       n_chars;
      int       n_pad;
      bit [7:0] c;
      n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 12);
      for (int k = 0; k < n_chars; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 4))
               0:       c = "=";
               1:       c = " ";
               2:       c = 8'h0A;
               3:       c = 8'h0D;
               default: c = 8'($urandom_range(0, 255));
            endcase
            text_q = {text_q, c};
         end
         text_q = {text_q, pick_b64_char()};
      end
      n_pad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
      repeat (n_pad) text_q = {text_q, 8'h3D};
      if (text_q.size() == 0) text_q = {text_q, 8'($urandom_range(0, 255))};
      foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
   endtask

   initial begin : main
      int stop_at;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_text_char   <= 8'h00;
      req_end_of_text <= 1'b0;
      burst_left       = 0;
      counted_items    = 0;
      hold_off_pending = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full group
      send_char("T", 1'b0); send_char("W", 1'b0); send_char("F", 1'b0);
      send_char("u", 1'b0);
      // group completed by the end character itself
      send_char("/", 1'b0); send_char("+", 1'b0); send_char("9", 1'b0);
      send_char("0", 1'b1);
      // alphabet edges mixed with skipped bytes
      send_char("A", 1'b0); send_char(8'h00, 1'b0); send_char("Z", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char("a", 1'b0); send_char("=", 1'b0); send_char("z", 1'b0);
      // three held, end lands on padding
      send_char("z", 1'b0); send_char("9", 1'b0); send_char("+", 1'b0);
      send_char("=", 1'b1);
      // two held
      send_char("0", 1'b0); send_char("/", 1'b1);
      // lone character dropped, then end with empty group
      send_char("Q", 1'b1);
      send_char(" ", 1'b1);
      wait_drained();

      // long receiver hold while the sender keeps pushing
      hold_off_pending = 1'b1;
      for (int k = 0; k < 24; k++) send_char(pick_b64_char(), k == 23);
      wait_drained();

      stop_at = counted_items + RANDOM_ITEMS;
      while (counted_items < stop_at) begin
         if ($urandom_range(0, 9) == 0) begin
            // raw noise, end flag at random
            repeat ($urandom_range(1, 8))
               send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         end else begin
            send_text();
         end
         if ($urandom_range(0, 9) == 0) wait_drained();
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* base64_lenient_decoder.f */
+incdir+hdl
hdl/b64d_pkg.sv
hdl/b64d_unpack.sv
hdl/base64_lenient_decoder.sv
hdl/b64d_checker.sv
dv/base64_lenient_decoder_tb.sv
